FILE: hw/rtl/srtf_pkg.sv
`default_nettype none

package srtf_pkg;

   // Fixed widths of the beat fields
   localparam int FIELD_W = 16;
   localparam int ID_W    = 5;

   // Item kinds carried in the mode field
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_UPD,
      S_TA,
      S_WT,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/srtf_if.sv
`default_nettype none

interface srtf_req_if import srtf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [FIELD_W-1:0] arrival_time;
   logic [FIELD_W-1:0] burst_time;

   modport source (output valid, output mode, output arrival_time, output burst_time,
                   input ready);
   modport sink   (input valid, input mode, input arrival_time, input burst_time,
                   output ready);
endinterface

interface srtf_rsp_if import srtf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [ID_W-1:0]    running_id;
   logic               completed;
   logic [ID_W-1:0]    finished_id;
   logic [FIELD_W-1:0] completion_time;
   logic [FIELD_W-1:0] turnaround_time;
   logic [FIELD_W-1:0] waiting_time;

   modport source (output valid, output accepted, output running_id, output completed,
                   output finished_id, output completion_time, output turnaround_time,
                   output waiting_time, input ready);
   modport sink   (input valid, input accepted, input running_id, input completed,
                   input finished_id, input completion_time, input turnaround_time,
                   input waiting_time, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srtf_ram.sv
`default_nettype none

module srtf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/srtf_scheduler.sv
// Load beat: S_OUT moves the result into the response register, then S_IDLE takes the
// next request. Tick beat: S_SCAN reads each loaded entry, then S_DRAIN, S_UPD (S_TA and
// S_WT when one finishes) and S_OUT; an empty table skips the scan.
// The scan reads one table entry per cycle from the process RAMs, so the fill sets the rate.
// One beat is in flight at a time; a stalled response holds in its own register.
// Reset (synchronous, active high) clears count, time, finished marks and control state.
`default_nettype none

module srtf_scheduler import srtf_pkg::*; #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   srtf_req_if.sink    req_if,
   srtf_rsp_if.source  rsp_if
);

   // Index into the table, and a count that can hold the table size itself
   localparam int IW   = $clog2(MAX_PROCS);
   localparam int CNTW = $clog2(MAX_PROCS + 1);
   // Working width for time arithmetic: wide enough for both time and field values
   localparam int XW   = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [MAX_PROCS-1:0] fin_ff, fin_in;

   // Scan sequencer: issue counter and the read in flight
   logic [CNTW-1:0]      scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [IW-1:0]        pidx_ff, pidx_in;

   // Best candidate so far
   logic                 found_ff, found_in;
   logic [IW-1:0]        bidx_ff, bidx_in;
   logic [FIELD_W-1:0]   brem_ff, brem_in;
   logic [FIELD_W-1:0]   barr_ff, barr_in;
   logic [FIELD_W-1:0]   bbur_ff, bbur_in;

   // Result being built
   logic                 racc_ff, racc_in;
   logic [ID_W-1:0]      rrun_ff, rrun_in;
   logic                 rdone_ff, rdone_in;
   logic [ID_W-1:0]      rfin_ff, rfin_in;
   logic [XW-1:0]        rct_ff, rct_in;
   logic [XW-1:0]        rta_ff, rta_in;
   logic [XW-1:0]        rwt_ff, rwt_in;

   // Response register
   logic                 ov_ff, ov_in;
   logic                 oacc_ff, oacc_in;
   logic [ID_W-1:0]      orun_ff, orun_in;
   logic                 odone_ff, odone_in;
   logic [ID_W-1:0]      ofin_ff, ofin_in;
   logic [FIELD_W-1:0]   oct_ff, oct_in;
   logic [FIELD_W-1:0]   ota_ff, ota_in;
   logic [FIELD_W-1:0]   owt_ff, owt_in;

   // ---------------------------------------------------------------------------
   // Process RAMs: {arrival, burst} written at load only; remaining read-modify-write
   // ---------------------------------------------------------------------------
   logic                   ab_we;
   logic [2*FIELD_W-1:0]   ab_wdata, ab_rdata;
   logic                   rem_we;
   logic [IW-1:0]          rem_waddr;
   logic [FIELD_W-1:0]     rem_wdata, rem_rdata;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;

   srtf_ram #(.WIDTH(2*FIELD_W), .DEPTH(MAX_PROCS)) u_ab_ram (
      .clock   (clock),
      .wr_en   (ab_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (ab_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ab_rdata)
   );

   srtf_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_PROCS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_waddr),
      .wr_data (rem_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rem_rdata)
   );

   // ---------------------------------------------------------------------------
   // Shared decode
   // ---------------------------------------------------------------------------
   logic                 req_acc;
   logic                 is_load;
   logic                 not_full;
   logic [FIELD_W-1:0]   load_burst;
   logic                 out_free;
   logic [FIELD_W-1:0]   rd_arr, rd_bur;
   logic                 cand_ok, cand_better;
   logic [FIELD_W-1:0]   new_rem;
   logic [IW:0]          best_id_wide;
   logic [ID_W-1:0]      best_id;

   assign req_acc    = req_if.valid && req_if.ready;
   assign is_load    = (req_if.mode == MODE_LOAD);
   assign not_full   = (count_ff < CNTW'(MAX_PROCS));
   // A zero burst is stored as one tick of work
   assign load_burst = (req_if.burst_time == '0) ? FIELD_W'(1) : req_if.burst_time;
   assign out_free   = !ov_ff || rsp_if.ready;

   assign rd_arr = ab_rdata[2*FIELD_W-1:FIELD_W];
   assign rd_bur = ab_rdata[FIELD_W-1:0];

   // Candidate must be unfinished and already arrived; ascending scan with strict
   // comparisons keeps the lower id on a full tie
   assign cand_ok     = pend_ff && !fin_ff[pidx_ff] && (XW'(rd_arr) <= XW'(time_ff));
   assign cand_better = !found_ff || (rem_rdata < brem_ff) ||
                        ((rem_rdata == brem_ff) && (rd_arr < barr_ff));

   assign new_rem      = (brem_ff != '0) ? brem_ff - FIELD_W'(1) : '0;
   assign best_id_wide = {1'b0, bidx_ff} + (IW+1)'(1);
   assign best_id      = ID_W'(best_id_wide);

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (is_load) begin
                  state_in = S_OUT;
               end else if (count_ff == '0) begin
                  state_in = S_UPD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff == count_ff - CNTW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_UPD;
         S_UPD: begin
            if (found_ff && (new_rem == '0)) begin
               state_in = S_TA;
            end else begin
               state_in = S_OUT;
            end
         end
         S_TA:  state_in = S_WT;
         S_WT:  state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Control outputs: handshake and RAM ports
   // ---------------------------------------------------------------------------
   always_comb begin
      req_if.ready = (state_ff == S_IDLE);
      ab_we        = 1'b0;
      ab_wdata     = {req_if.arrival_time, load_burst};
      rem_we       = 1'b0;
      rem_waddr    = count_ff[IW-1:0];
      rem_wdata    = load_burst;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            // Store the new process at the next free slot
            if (req_acc && is_load && not_full) begin
               ab_we  = 1'b1;
               rem_we = 1'b1;
            end
         end
         S_SCAN: rd_en = 1'b1;
         S_UPD: begin
            // Write back the served process's remaining time
            if (found_ff) begin
               rem_we    = 1'b1;
               rem_waddr = bidx_ff;
               rem_wdata = new_rem;
            end
         end
         S_DRAIN, S_TA, S_WT, S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------------
   always_comb begin
      count_in = count_ff;
      time_in  = time_ff;
      fin_in   = fin_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      found_in = found_ff;
      bidx_in  = bidx_ff;
      brem_in  = brem_ff;
      barr_in  = barr_ff;
      bbur_in  = bbur_ff;
      racc_in  = racc_ff;
      rrun_in  = rrun_ff;
      rdone_in = rdone_ff;
      rfin_in  = rfin_ff;
      rct_in   = rct_ff;
      rta_in   = rta_ff;
      rwt_in   = rwt_ff;
      ov_in    = ov_ff;
      oacc_in  = oacc_ff;
      orun_in  = orun_ff;
      odone_in = odone_ff;
      ofin_in  = ofin_ff;
      oct_in   = oct_ff;
      ota_in   = ota_ff;
      owt_in   = owt_ff;

      // Drop the response once the sink takes it
      if (ov_ff && rsp_if.ready) begin
         ov_in = 1'b0;
      end

      // Fold the returning RAM read into the best candidate
      if ((state_ff == S_SCAN || state_ff == S_DRAIN) && cand_ok && cand_better) begin
         found_in = 1'b1;
         bidx_in  = pidx_ff;
         brem_in  = rem_rdata;
         barr_in  = rd_arr;
         bbur_in  = rd_bur;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               racc_in  = 1'b0;
               rrun_in  = '0;
               rdone_in = 1'b0;
               rfin_in  = '0;
               rct_in   = '0;
               rta_in   = '0;
               rwt_in   = '0;
               found_in = 1'b0;
               scan_in  = '0;
               pend_in  = 1'b0;
               if (is_load && not_full) begin
                  racc_in                   = 1'b1;
                  fin_in[count_ff[IW-1:0]]  = 1'b0;
                  count_in                  = count_ff + CNTW'(1);
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + CNTW'(1);
            pend_in = 1'b1;
            pidx_in = scan_ff[IW-1:0];
         end
         S_DRAIN: begin
            pend_in = 1'b0;
         end
         S_UPD: begin
            // Advance time, holding at the top
            if (time_ff != '1) begin
               time_in = time_ff + TIME_BITS'(1);
            end
            if (found_ff) begin
               rrun_in = best_id;
               if (new_rem == '0) begin
                  fin_in[bidx_ff] = 1'b1;
                  rdone_in        = 1'b1;
                  rfin_in         = best_id;
                  rct_in          = XW'(time_in);
               end
            end
         end
         S_TA: begin
            rta_in = (rct_ff >= XW'(barr_ff)) ? rct_ff - XW'(barr_ff) : '0;
         end
         S_WT: begin
            rwt_in = (rta_ff >= XW'(bbur_ff)) ? rta_ff - XW'(bbur_ff) : '0;
         end
         S_OUT: begin
            // Move the result into the response register, saturating the times
            if (out_free) begin
               ov_in    = 1'b1;
               oacc_in  = racc_ff;
               orun_in  = rrun_ff;
               odone_in = rdone_ff;
               ofin_in  = rfin_ff;
               oct_in   = (rct_ff > XW'({FIELD_W{1'b1}})) ? '1 : rct_ff[FIELD_W-1:0];
               ota_in   = (rta_ff > XW'({FIELD_W{1'b1}})) ? '1 : rta_ff[FIELD_W-1:0];
               owt_in   = (rwt_ff > XW'({FIELD_W{1'b1}})) ? '1 : rwt_ff[FIELD_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         time_ff  <= '0;
         fin_ff   <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         time_ff  <= time_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      pidx_ff  <= pidx_in;
      bidx_ff  <= bidx_in;
      brem_ff  <= brem_in;
      barr_ff  <= barr_in;
      bbur_ff  <= bbur_in;
      racc_ff  <= racc_in;
      rrun_ff  <= rrun_in;
      rdone_ff <= rdone_in;
      rfin_ff  <= rfin_in;
      rct_ff   <= rct_in;
      rta_ff   <= rta_in;
      rwt_ff   <= rwt_in;
      oacc_ff  <= oacc_in;
      orun_ff  <= orun_in;
      odone_ff <= odone_in;
      ofin_ff  <= ofin_in;
      oct_ff   <= oct_in;
      ota_ff   <= ota_in;
      owt_ff   <= owt_in;
   end

   // ---------------------------------------------------------------------------
   // Response beat
   // ---------------------------------------------------------------------------
   assign rsp_if.valid           = ov_ff;
   assign rsp_if.accepted        = oacc_ff;
   assign rsp_if.running_id      = orun_ff;
   assign rsp_if.completed       = odone_ff;
   assign rsp_if.finished_id     = ofin_ff;
   assign rsp_if.completion_time = oct_ff;
   assign rsp_if.turnaround_time = ota_ff;
   assign rsp_if.waiting_time    = owt_ff;

endmodule

`default_nettype wire

FILE: verif/srtf_scheduler_test.sv
`timescale 1ns / 1ps

module srtf_scheduler_test;
   import srtf_pkg::*;

   localparam int                 TABLE_SIZE   = 16;
   localparam logic [FIELD_W-1:0] TIME_MAX     = '1;
   // Beats of the two random stretches
   localparam int                 SPREAD_A     = 600;
   localparam int                 SPREAD_B     = 700;
   localparam int                 LOADS_A      = 4;
   // Long receiver hold-off: when it starts and how many cycles it lasts
   localparam int                 HOLD_AT      = 200;
   localparam int                 HOLD_SPAN    = 400;
   localparam int                 STALL_LIMIT  = 5000;

   // One request beat: a load (arrival, burst) or a tick (payload ignored)
   typedef struct packed {
      logic               mode;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] burst;
   } sched_beat_type;

   // One response beat, in the order of the response interface
   typedef struct packed {
      logic               accepted;
      logic [ID_W-1:0]    running_id;
      logic               completed;
      logic [ID_W-1:0]    finished_id;
      logic [FIELD_W-1:0] completion;
      logic [FIELD_W-1:0] turnaround;
      logic [FIELD_W-1:0] waiting;
   } sched_result_type;

   logic clock;
   logic reset = 1'b1;

   srtf_req_if req_chan ();
   srtf_rsp_if rsp_chan ();

   srtf_scheduler #(
      .MAX_PROCS (TABLE_SIZE),
      .TIME_BITS (FIELD_W)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // ---------------------------------------------------------------------
   // Scheduler state as this bench sees it
   // ---------------------------------------------------------------------
   logic [FIELD_W-1:0] arrival_tab [TABLE_SIZE];
   logic [FIELD_W-1:0] burst_tab   [TABLE_SIZE];
   logic [FIELD_W-1:0] remain_tab  [TABLE_SIZE];
   logic               done_tab    [TABLE_SIZE];
   int unsigned        loaded         = 0;
   int unsigned        finished_total = 0;
   logic [FIELD_W-1:0] clock_now      = '0;

   sched_beat_type   pending   [$];   // beats waiting to be offered
   sched_result_type outcome_q [$];   // responses owed by the block, oldest first

   // Run statistics
   int unsigned stored_loads  = 0;
   int unsigned refused_loads = 0;
   int unsigned busy_ticks    = 0;
   int unsigned idle_ticks    = 0;
   int unsigned beats_in      = 0;
   int unsigned results_seen  = 0;
   int unsigned error_count   = 0;

   // Stimulus shaping
   int unsigned gen_ticks  = 0;     // ticks queued so far, i.e. the clock at the queue tail
   int unsigned gap_left   = 0;
   int unsigned burst_left = 0;
   int unsigned hold_left  = 0;
   logic        hold_done  = 1'b0;
   logic [7:0]  ready_pattern = 8'hFF;
   int unsigned pattern_age   = 0;
   int unsigned quiet_cycles  = 0;

   sched_beat_type   offer_beat;
   sched_result_type seen_result;
   sched_result_type due_result;

   // Work out the response to one accepted beat and queue it.
   // A tick picks the arrived, unfinished process with the least remaining time;
   // ties go to the earlier arrival, then to the lower slot (scan order).
   function automatic void schedule_beat(input sched_beat_type beat);
      sched_result_type   outcome;
      int                 pick;
      int                 idx;
      bit                 found;
      logic [FIELD_W-1:0] span;
      outcome = '0;
      if (beat.mode == MODE_LOAD) begin
         if (loaded < TABLE_SIZE) begin
            arrival_tab[loaded] = beat.arrival;
            // a zero burst is stored as one
            burst_tab[loaded]   = (beat.burst == '0) ? FIELD_W'(1) : beat.burst;
            remain_tab[loaded]  = burst_tab[loaded];
            done_tab[loaded]    = 1'b0;
            loaded++;
            stored_loads++;
            outcome.accepted = 1'b1;
         end else begin
            // full table: refuse, change nothing
            refused_loads++;
         end
      end else begin
         found = 1'b0;
         pick  = 0;
         for (idx = 0; idx < loaded; idx++) begin
            if (!done_tab[idx] && arrival_tab[idx] <= clock_now) begin
               if (!found || remain_tab[idx] < remain_tab[pick] ||
                   (remain_tab[idx] == remain_tab[pick] &&
                    arrival_tab[idx] < arrival_tab[pick])) begin
                  pick  = idx;
                  found = 1'b1;
               end
            end
         end
         // the clock sticks at its top value
         if (clock_now != TIME_MAX) clock_now++;
         if (!found) begin
            idle_ticks++;
         end else begin
            busy_ticks++;
            outcome.running_id = ID_W'(pick + 1);
            remain_tab[pick]--;
            if (remain_tab[pick] == '0) begin
               done_tab[pick] = 1'b1;
               finished_total++;
               outcome.completed   = 1'b1;
               outcome.finished_id = ID_W'(pick + 1);
               outcome.completion  = clock_now;
               span = (clock_now >= arrival_tab[pick]) ? clock_now - arrival_tab[pick] : '0;
               outcome.turnaround  = span;
               // turnaround below the burst only once the clock has saturated: clamp
               outcome.waiting     = (span >= burst_tab[pick]) ? span - burst_tab[pick] : '0;
            end
         end
      end
      outcome_q.push_back(outcome);
   endfunction

   function automatic void push_load(input logic [FIELD_W-1:0] arrival,
                                     input logic [FIELD_W-1:0] burst);
      sched_beat_type beat;
      beat.mode    = MODE_LOAD;
      beat.arrival = arrival;
      beat.burst   = burst;
      pending.push_back(beat);
   endfunction

   // Ticks carry random payload: the block must ignore it
   function automatic void push_tick();
      sched_beat_type beat;
      beat.mode    = MODE_TICK;
      beat.arrival = FIELD_W'($urandom);
      beat.burst   = FIELD_W'($urandom);
      pending.push_back(beat);
      gen_ticks++;
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      $display("ERROR %0t: %s", $realtime, msg);
   endtask

   // Hold until every queued beat is offered and every response is back
   task automatic drain();
      while (pending.size() != 0 || req_chan.valid || outcome_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: offer queued beats in bursts of random length, with
   // random gaps after a burst's last beat is taken. Hold valid and payload
   // steady until the beat is accepted.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.mode         <= MODE_LOAD;
         req_chan.arrival_time <= '0;
         req_chan.burst_time   <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            schedule_beat(offer_beat);
            beats_in++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0 || pending.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_chan.valid <= 1'b0;
            end else begin
               offer_beat = pending.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.mode         <= offer_beat.mode;
               req_chan.arrival_time <= offer_beat.arrival;
               req_chan.burst_time   <= offer_beat.burst;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // burst over: draw the next one and the gap in front of it
                  burst_left = $urandom_range(1, 32);
                  if ($urandom_range(0, 7) == 0)
                     gap_left = $urandom_range(20, 60);
                  else
                     gap_left = $urandom_range(0, 4);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: stall on a rotating pattern, redrawn whenever
   // its age counter runs out (sometimes all ready), plus one long
   // hold-off that fills the block and backs up the request side.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_SPAN;
            hold_done = 1'b1;
         end
         if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            pattern_age   = 32;
         end
         pattern_age--;
         ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ready_pattern[0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: check each accepted beat against the oldest
   // expectation, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_result = {rsp_chan.accepted, rsp_chan.running_id, rsp_chan.completed,
                        rsp_chan.finished_id, rsp_chan.completion_time,
                        rsp_chan.turnaround_time, rsp_chan.waiting_time};
         results_seen++;
         if (outcome_q.size() == 0) begin
            log_error($sformatf("response %0d arrived with nothing owed", results_seen));
         end else begin
            due_result = outcome_q.pop_front();
            if (seen_result.accepted !== due_result.accepted)
               log_error($sformatf("response %0d accepted %b, want %b", results_seen,
                                   seen_result.accepted, due_result.accepted));
            if (seen_result.running_id !== due_result.running_id)
               log_error($sformatf("response %0d running_id %0d, want %0d", results_seen,
                                   seen_result.running_id, due_result.running_id));
            if (seen_result.completed !== due_result.completed)
               log_error($sformatf("response %0d completed %b, want %b", results_seen,
                                   seen_result.completed, due_result.completed));
            if (seen_result.finished_id !== due_result.finished_id)
               log_error($sformatf("response %0d finished_id %0d, want %0d", results_seen,
                                   seen_result.finished_id, due_result.finished_id));
            if (seen_result.completion !== due_result.completion)
               log_error($sformatf("response %0d completion_time %h, want %h", results_seen,
                                   seen_result.completion, due_result.completion));
            if (seen_result.turnaround !== due_result.turnaround)
               log_error($sformatf("response %0d turnaround_time %h, want %h", results_seen,
                                   seen_result.turnaround, due_result.turnaround));
            if (seen_result.waiting !== due_result.waiting)
               log_error($sformatf("response %0d waiting_time %h, want %h", results_seen,
                                   seen_result.waiting, due_result.waiting));
         end
      end
   end

   // Watchdog: give up when neither side has moved a beat for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles, %0d responses owed",
                  STALL_LIMIT, outcome_q.size());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned k;
      int unsigned load_no;
      int unsigned next_at;
      logic [FIELD_W-1:0] arr;
      logic [FIELD_W-1:0] bur;

      // Directed opening: empty-table idle tick, zero burst, a process not yet
      // arrived, ties on remaining time settled by arrival and then by id, and
      // a process arriving at the top of the clock range.
      push_tick();                   // empty table: idle
      push_load('0, '0);             // id 1, burst taken as one
      push_load(16'd3, 16'd2);       // id 2, arrives later
      push_tick();                   // id 1 runs and finishes
      push_tick();                   // id 2 not arrived yet: idle
      push_load(16'd3, 16'd2);       // id 3 ties id 2 outright
      push_load(16'd2, 16'd2);       // id 4 ties on remaining, earlier arrival
      push_load(TIME_MAX, 16'd1);    // id 5 only ready once the clock saturates
      repeat (7) push_tick();        // 4, 4, 2, 2, 3, 3, then idle

      // First random stretch: mostly ticks, a few loads arriving near the
      // current clock, one very long job and one due far in the future.
      load_no = 0;
      next_at = $urandom_range(0, SPREAD_A / LOADS_A - 1);
      for (k = 0; k < SPREAD_A; k++) begin
         if (load_no < LOADS_A && k == next_at) begin
            case (load_no)
               1: push_load(FIELD_W'(gen_ticks + $urandom_range(0, 40)),
                            16'h8000 | FIELD_W'($urandom_range(0, 255)));
               2: push_load(FIELD_W'($urandom_range(65000, 65400)),
                            FIELD_W'($urandom_range(200, 600)));
               default: push_load(FIELD_W'(gen_ticks + $urandom_range(0, 40)),
                                  FIELD_W'($urandom_range(1, 30)));
            endcase
            load_no++;
            next_at = load_no * (SPREAD_A / LOADS_A) + $urandom_range(0, SPREAD_A / LOADS_A - 1);
         end else begin
            push_tick();
         end
      end
      drain();

      // Second random stretch: fill the table with mixed arrivals and bursts,
      // then keep offering loads that are refused.
      load_no = 0;
      for (k = 0; k < SPREAD_B; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 7))
               0:       arr = '0;
               1:       arr = TIME_MAX;
               2:       arr = FIELD_W'($urandom);
               default: arr = FIELD_W'(gen_ticks + $urandom_range(0, 60));
            endcase
            if (load_no == 2)
               bur = '1;
            else if ($urandom_range(0, 11) == 0)
               bur = '0;
            else if ($urandom_range(0, 5) == 0)
               bur = FIELD_W'($urandom_range(1, 65535));
            else
               bur = FIELD_W'($urandom_range(1, 24));
            push_load(arr, bur);
            load_no++;
         end else begin
            push_tick();
         end
      end
      drain();
      repeat (40) @(posedge clock);

      $display("Run covered %0d beats: %0d loads stored, %0d refused on a full table",
               beats_in, stored_loads, refused_loads);
      $display("%0d busy and %0d idle ticks, %0d processes finished, clock ended at %0d",
               busy_ticks, idle_ticks, finished_total, clock_now);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hold reset at start-up, then release it; it is never raised again
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

FILE: sim.f
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_if.sv
hw/rtl/srtf_ram.sv
hw/rtl/srtf_scheduler.sv
verif/srtf_scheduler_test.sv
